// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define RY_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RY_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ry420_pkg.sv =====
// ----------------------------------------------------------------------------
// ry420_pkg
// Shared widths, register indexes, coefficients and types for the
// RGB to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ry420_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned REG_W      = 13;
  localparam int unsigned COUNT_W    = 12;
  localparam int unsigned COUNT_SPAN = 4096;
  localparam int unsigned ACC_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 13'd320;
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 13'd240;

  // BT.601 studio swing, Q8
  localparam logic [ACC_W-1:0] Y_R  = 16'd66;
  localparam logic [ACC_W-1:0] Y_G  = 16'd129;
  localparam logic [ACC_W-1:0] Y_B  = 16'd25;
  localparam logic [ACC_W-1:0] CB_R = 16'd38;
  localparam logic [ACC_W-1:0] CB_G = 16'd74;
  localparam logic [ACC_W-1:0] CB_B = 16'd112;
  localparam logic [ACC_W-1:0] CR_R = 16'd112;
  localparam logic [ACC_W-1:0] CR_G = 16'd94;
  localparam logic [ACC_W-1:0] CR_B = 16'd18;
  localparam logic [ACC_W-1:0] Y_OFFSET = 16'd4096;   // 16 << 8
  localparam logic [ACC_W-1:0] C_OFFSET = 16'd32768;  // 128 << 8

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic chroma_valid;
    logic frame_end;
  } pos_flags_t;

endpackage

// ===== sv/ry420_position.sv =====
// ----------------------------------------------------------------------------
// ry420_position
// Frame size registers and raster position counters; flags the chroma
// sites and the last pixel of the frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ry420_position #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [ry420_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ry420_pkg::REG_W-1:0]      cfg_wdata,
  input  logic                             advance,
  output ry420_pkg::pos_flags_t            flags
);
  import ry420_pkg::*;

  localparam int unsigned W_LIM = (MAX_WIDTH  > COUNT_SPAN) ? COUNT_SPAN : MAX_WIDTH;
  localparam int unsigned H_LIM = (MAX_HEIGHT > COUNT_SPAN) ? COUNT_SPAN : MAX_HEIGHT;
  localparam logic [REG_W-1:0] W_LIM_V = REG_W'(W_LIM);
  localparam logic [REG_W-1:0] H_LIM_V = REG_W'(H_LIM);

  logic [REG_W-1:0]   frame_width_r,  frame_width_nxt;
  logic [REG_W-1:0]   frame_height_r, frame_height_nxt;
  logic [COUNT_W-1:0] column_count_r, column_count_nxt;
  logic [COUNT_W-1:0] row_count_r,    row_count_nxt;
  logic [REG_W-1:0]   width_cl, height_cl;
  logic [COUNT_W-1:0] last_col, last_row;
  logic               col_end, row_end;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp to limit, zero reads as one, then last index
  always_comb begin
    width_cl  = (frame_width_r  > W_LIM_V) ? W_LIM_V : frame_width_r;
    height_cl = (frame_height_r > H_LIM_V) ? H_LIM_V : frame_height_r;
    if (width_cl == '0) width_cl = REG_W'(1);
    if (height_cl == '0) height_cl = REG_W'(1);
    last_col = COUNT_W'(width_cl  - REG_W'(1));
    last_row = COUNT_W'(height_cl - REG_W'(1));
  end

  // >= so a shrunk size mid-frame wraps on the next pixel
  assign col_end = (column_count_r >= last_col);
  assign row_end = (row_count_r    >= last_row);

  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    if (advance) begin
      if (col_end) begin
        column_count_nxt = '0;
        row_count_nxt    = row_end ? '0 : row_count_r + COUNT_W'(1);
      end else begin
        column_count_nxt = column_count_r + COUNT_W'(1);
      end
    end
  end

  assign flags.chroma_valid = ~column_count_r[0] & ~row_count_r[0];
  assign flags.frame_end    = col_end & row_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      column_count_r <= '0;
      row_count_r    <= '0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

endmodule

// ===== sv/ry420_colour_math.sv =====
// ----------------------------------------------------------------------------
// ry420_colour_math
// BT.601 RGB to YCbCr in Q8, truncating; chroma forced to zero off-site.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ry420_colour_math (
  input  ry420_pkg::pixel_t            pix,
  input  logic                         chroma_valid,
  output logic [ry420_pkg::PIX_W-1:0]  luma,
  output logic [ry420_pkg::PIX_W-1:0]  chroma_blue,
  output logic [ry420_pkg::PIX_W-1:0]  chroma_red
);
  import ry420_pkg::*;

  logic [ACC_W-1:0] r_w, g_w, b_w;
  logic [ACC_W-1:0] y_sum, cb_sum, cr_sum;

  assign r_w = ACC_W'(pix.red);
  assign g_w = ACC_W'(pix.green);
  assign b_w = ACC_W'(pix.blue);

  // True sums stay in 0..65535, so modulo 2^16 arithmetic is exact
  assign y_sum  = Y_R * r_w + Y_G * g_w + Y_B * b_w + Y_OFFSET;
  assign cb_sum = CB_B * b_w + C_OFFSET - CB_R * r_w - CB_G * g_w;
  assign cr_sum = CR_R * r_w + C_OFFSET - CR_G * g_w - CR_B * b_w;

  assign luma        = y_sum[ACC_W-1 -: PIX_W];
  assign chroma_blue = chroma_valid ? cb_sum[ACC_W-1 -: PIX_W] : '0;
  assign chroma_red  = chroma_valid ? cr_sum[ACC_W-1 -: PIX_W] : '0;

endmodule

// ===== sv/rgb_to_yuv420_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter
// RGB888 raster pixels in, BT.601 studio-swing Y per pixel plus Cb/Cr on
// the top-left pixel of each 2x2 block (4:2:0), end-of-frame on tlast.
// ----------------------------------------------------------------------------
//
//  channel   | dir | contents
//  ----------+-----+-------------------------------------------------------
//  in_*      | in  | one RGB pixel per word, raster order
//  out_*     | out | Y, Cb, Cr per word; tuser = chroma site, tlast = frame end
//  cfg_*     | in  | frame_width (index 0), frame_height (index 1)
//
//  Throughput one word per clock while out_tready is high. The accept edge
//  loads the input register; the colour maths then fills the output register
//  once that register is free, which raises out_tvalid.
//  Synchronous active-low reset clears both valid flags and the position
//  counters and restores 320 x 240.
//  out_tready low holds the output word; the input register then fills and
//  in_tready drops only when both registers hold a word.
//  Frame size writes are meant for an idle block; a column counter beyond a
//  reduced width wraps on the next pixel, a row counter at the next row end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_yuv420_converter #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel words
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // red, green, blue
  // converted words
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // luma, chroma_blue, chroma_red
  output logic                            out_tlast,  // frame_end
  output logic                            out_tuser,  // chroma_valid
  // frame size registers
  input  logic                            cfg_wr_en,
  input  logic [ry420_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ry420_pkg::REG_W-1:0]     cfg_wdata
);
  import ry420_pkg::*;

  logic       in_fire, a_ready, a_fire;
  logic       a_valid_r, a_valid_nxt;
  pixel_t     a_pix_r;
  pos_flags_t a_flags_r;
  pos_flags_t pos_flags;
  logic       out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r;
  logic       out_last_r, out_user_r;
  logic [PIX_W-1:0] luma, chroma_blue, chroma_red;

  // Ready chains back from the output register through the input register
  assign a_ready   = ~out_valid_r | out_tready;
  assign in_tready = ~a_valid_r | a_ready;
  assign in_fire   = in_tvalid & in_tready;
  assign a_fire    = a_valid_r & a_ready;

  // Counters step on every accepted pixel; flags belong to that pixel
  ry420_position #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_position (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (in_fire),
    .flags     (pos_flags)
  );

  ry420_colour_math u_colour_math (
    .pix          (a_pix_r),
    .chroma_valid (a_flags_r.chroma_valid),
    .luma         (luma),
    .chroma_blue  (chroma_blue),
    .chroma_red   (chroma_red)
  );

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_fire)     a_valid_nxt = 1'b1;
    else if (a_fire) a_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (a_fire)          out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_pix_r.red   <= in_tdata[7:0];
      a_pix_r.green <= in_tdata[15:8];
      a_pix_r.blue  <= in_tdata[23:16];
      a_flags_r     <= pos_flags;
    end
    if (a_fire) begin
      out_data_r <= {chroma_red, chroma_blue, luma};
      out_last_r <= a_flags_r.frame_end;
      out_user_r <= a_flags_r.chroma_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== sv/ry420_checker.sv =====
// ----------------------------------------------------------------------------
// ry420_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ry420_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  logic frame_start_r;
  logic out_fire;

  assign out_fire = out_tvalid & out_tready;

  // Next output word opens a frame: after reset or after a tlast word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_start_r <= 1'b1;
    end else if (out_fire) begin
      frame_start_r <= out_tlast;
    end
  end

  `RY_ASSERT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled output word changed")
  `RY_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")
  `RY_ASSERT(a_word_has_source, clk, rst_n, $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2), "output word without matching input two clocks earlier")
  `RY_ASSERT(a_frame_start_chroma, clk, rst_n, out_fire && frame_start_r |-> out_tuser, "first pixel of a frame lacks chroma")

endmodule

bind rgb_to_yuv420_converter ry420_checker u_ry420_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_to_yuv420_converter: drives RGB words, predicts
// Y/Cb/Cr and the chroma-site and frame-end flags, and checks each output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ry420_pkg::*;

  localparam int unsigned MAX_W        = 4096;
  localparam int unsigned MAX_H        = 4096;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned LIMIT_CYCLES = 500000;

  // One converted word as the block should give it
  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
    logic             chroma_valid;
    logic             frame_end;
  } yuv_word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;     // red, green, blue
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;    // luma, chroma_blue, chroma_red
  logic                 out_tlast;    // frame_end
  logic                 out_tuser;    // chroma_valid
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_wdata;

  // Predictor copy of the frame size registers and position counters
  logic [REG_W-1:0]   frame_w_reg;
  logic [REG_W-1:0]   frame_h_reg;
  logic [COUNT_W-1:0] pix_col;
  logic [COUNT_W-1:0] pix_row;

  yuv_word_t   yuv_expect_q[$];
  int unsigned mismatch_count;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  rgb_to_yuv420_converter #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[rgb_to_yuv420_converter] ERROR");
      $finish;
    end
  end

  // Receiver back-pressure; one assignment per edge
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Last column/row index from a register value: 0 acts as 1, and anything
  // above the counter span (or the MAX parameter) is clipped to it.
  function automatic logic [COUNT_W-1:0] last_pos(logic [REG_W-1:0] reg_val,
                                                   int unsigned max_dim);
    int unsigned n;
    int unsigned lim;
    lim = (max_dim > COUNT_SPAN) ? COUNT_SPAN : max_dim;
    n   = reg_val;
    if (n > lim) n = lim;
    if (n == 0) n = 1;
    return COUNT_W'(n - 1);
  endfunction

  // Converts one pixel and steps the raster position
  function automatic yuv_word_t predict_yuv(pixel_t px);
    yuv_word_t          w;
    int                 r;
    int                 g;
    int                 b;
    logic [COUNT_W-1:0] lc;
    logic [COUNT_W-1:0] lr;
    logic               col_end;
    logic               row_end;
    r  = px.red;
    g  = px.green;
    b  = px.blue;
    lc = last_pos(frame_w_reg, MAX_W);
    lr = last_pos(frame_h_reg, MAX_H);

    w.luma = PIX_W'((int'(Y_R) * r + int'(Y_G) * g + int'(Y_B) * b
                     + int'(Y_OFFSET)) >>> 8);
    w.chroma_valid = !pix_col[0] && !pix_row[0];
    if (w.chroma_valid) begin
      w.chroma_blue = PIX_W'((int'(CB_B) * b + int'(C_OFFSET)
                              - int'(CB_R) * r - int'(CB_G) * g) >>> 8);
      w.chroma_red  = PIX_W'((int'(CR_R) * r + int'(C_OFFSET)
                              - int'(CR_G) * g - int'(CR_B) * b) >>> 8);
    end else begin
      w.chroma_blue = '0;
      w.chroma_red  = '0;
    end

    // ">=" so that a column counter left beyond a shrunk row wraps at once
    col_end     = (pix_col >= lc);
    row_end     = (pix_row >= lr);
    w.frame_end = col_end && row_end;
    if (col_end) begin
      pix_col = '0;
      pix_row = row_end ? '0 : pix_row + COUNT_W'(1);
    end else begin
      pix_col = pix_col + COUNT_W'(1);
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: sampled mid-cycle, word taken at the following edge
  // --------------------------------------------------------------------------

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(negedge clk) begin : result_check
    yuv_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (yuv_expect_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h/%b/%b",
                 $time, out_tdata, out_tuser, out_tlast);
        mismatch_count++;
      end else begin
        want = yuv_expect_q.pop_front();
        check_field("luma",         int'(want.luma),         int'(out_tdata[7:0]));
        check_field("chroma_blue",  int'(want.chroma_blue),  int'(out_tdata[15:8]));
        check_field("chroma_red",   int'(want.chroma_red),   int'(out_tdata[23:16]));
        check_field("chroma_valid", int'(want.chroma_valid), int'(out_tuser));
        check_field("frame_end",    int'(want.frame_end),    int'(out_tlast));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared driving tasks; each starts and ends on a rising edge
  // --------------------------------------------------------------------------

  // Sends one pixel word. tvalid is left high on return so back-to-back
  // words go out without a bubble; send gaps and drain_results lower it.
  task automatic send_pixel(pixel_t px);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    yuv_expect_q.push_back(predict_yuv(px));
  endtask

  // Holds the sender off until every expected word has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (yuv_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both size registers on consecutive edges while the block is idle
  task automatic set_frame_size(logic [REG_W-1:0] width, logic [REG_W-1:0] height);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= width;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= height;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frame_w_reg = width;
    frame_h_reg = height;
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t px;
    logic [PIX_W-1:0] ch[3];
    foreach (ch[i]) begin
      case ($urandom_range(7))
        0:       ch[i] = '0;
        1:       ch[i] = '1;
        default: ch[i] = PIX_W'($urandom);
      endcase
    end
    px.red   = ch[0];
    px.green = ch[1];
    px.blue  = ch[2];
    return px;
  endfunction

  function automatic pixel_t rgb(int r, int g, int b);
    pixel_t px;
    px.red   = PIX_W'(r);
    px.green = PIX_W'(g);
    px.blue  = PIX_W'(b);
    return px;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Colour extremes at the reset size of 320 x 240
  task automatic test_colour_extremes();
    send_pixel(rgb(0,   0,   0));
    send_pixel(rgb(255, 255, 255));
    send_pixel(rgb(255, 0,   0));     // largest Cr
    send_pixel(rgb(0,   255, 0));     // pure green
    send_pixel(rgb(0,   0,   255));   // largest Cb
    send_pixel(rgb(0,   255, 255));
    send_pixel(rgb(255, 0,   255));
    send_pixel(rgb(255, 255, 0));     // smallest Cb
    send_pixel(rgb(128, 128, 128));
    send_pixel(rgb(85,  170, 85));
  endtask

  // Column counter sits at 10, beyond a 4-wide row, so it must wrap next pixel
  task automatic test_mid_frame_resize();
    set_frame_size(13'd4, 13'd2);
    repeat (6) send_pixel(rand_pixel());
  endtask

  // Zero and odd sizes
  task automatic test_degenerate_sizes();
    set_frame_size(13'd0, 13'd0);       // 1 x 1: every word ends a frame
    repeat (2) send_pixel(rand_pixel());
    set_frame_size(13'd3, 13'd1);       // odd width, single row
    repeat (5) send_pixel(rand_pixel());
    set_frame_size(13'd1, 13'd3);       // single column, odd height
    repeat (3) send_pixel(rand_pixel());
  endtask

  // Largest sizes: an oversize width clips to a 4096-pixel row, so no
  // early frame end
  task automatic test_widest_row();
    set_frame_size(13'h1FFF, 13'd0);
    repeat (6) send_pixel(rand_pixel());
    set_frame_size(13'd4096, 13'd4096);
    repeat (6) send_pixel(rand_pixel());
    set_frame_size(13'd2, 13'd4096);
    repeat (6) send_pixel(rand_pixel());
  endtask

  // Runs of up to two small frames plus two words with random content, sizes
  // changed between runs (often mid-frame), with the odd full drain of the pipe
  task automatic test_random_frames(int unsigned gap_pct, int unsigned stall_pct,
                                    int unsigned n_words);
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned run;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_words) begin
      w = 2 * $urandom_range(1, 4);
      h = 2 * $urandom_range(1, 4);
      if ($urandom_range(4) == 0) w = $urandom_range(0, 7);
      if ($urandom_range(4) == 0) h = $urandom_range(0, 7);
      set_frame_size(REG_W'(w), REG_W'(h));
      run = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      run = $urandom_range(1, 2 * run + 2);
      repeat (run) begin
        send_pixel(rand_pixel());
        if ($urandom_range(49) == 0) drain_results();
        sent++;
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= REG_FRAME_WIDTH;
    cfg_wdata      <= '0;
    mismatch_count = 0;
    send_gap_pct   = 11;
    recv_stall_pct = 86;
    frame_w_reg    = FRAME_WIDTH_RST;
    frame_h_reg    = FRAME_HEIGHT_RST;
    pix_col        = '0;
    pix_row        = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_colour_extremes();
    test_mid_frame_resize();
    test_degenerate_sizes();
    test_widest_row();
    test_random_frames(11, 86, 200);
    test_random_frames(86, 11, 200);
    test_random_frames(0,  0,  200);

    drain_results();
    if (mismatch_count == 0 && yuv_expect_q.size() == 0) begin
      $display("[rgb_to_yuv420_converter] OK");
    end else begin
      $display("[rgb_to_yuv420_converter] ERROR");
    end
    $finish;
  end

endmodule
